>>> rtl/core/pbf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbf_pkg: shared types and constants of the partitioned Bloom filter
// Store geometry, register map, operation codes and the words moved between
// the front end, the back end and the ports.
// ----------------------------------------------------------------------------
package pbf_pkg;

    localparam int MAX_ROWS      = 4;
    localparam int MAX_ROW_WORDS = 32;
    localparam int MAX_HASHES    = 8;

    localparam int WORD_W      = 32;
    localparam int BIT_IDX_W   = $clog2(WORD_W);
    localparam int STORE_WORDS = MAX_ROWS * MAX_ROW_WORDS;
    localparam int ADDR_W      = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

    localparam int ROWS_CNT_W   = $clog2(MAX_ROWS + 1);
    localparam int WORDS_W      = $clog2(MAX_ROW_WORDS + 1);
    localparam int HASHES_CNT_W = $clog2(MAX_HASHES + 1);
    localparam int ROW_W        = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int HASH_W       = (MAX_HASHES > 1) ? $clog2(MAX_HASHES) : 1;
    localparam int REM_W        = $clog2(MAX_ROW_WORDS) + 1;

    // word index = (hash >> 5) mod row_words, MOD_STEP quotient bits a cycle
    localparam int DIV_BITS   = WORD_W - BIT_IDX_W;
    localparam int MOD_STEP   = 7;
    localparam int MOD_CYCLES = (DIV_BITS + MOD_STEP - 1) / MOD_STEP;
    localparam int DIV_PAD    = MOD_CYCLES * MOD_STEP;
    localparam int MOD_CNT_W  = (MOD_CYCLES > 1) ? $clog2(MOD_CYCLES) : 1;

    localparam int KEY_BYTES = WORD_W / 8;
    localparam int BYTE_W    = $clog2(KEY_BYTES);

    localparam logic [WORD_W-1:0] MIX_MUL  = 32'd7;
    localparam logic [WORD_W-1:0] ROW_ADD  = 32'd13;
    localparam logic [WORD_W-1:0] HASH_ADD = 32'd31;
    localparam logic [WORD_W-1:0] BIT_ONE  = 32'h1;
    localparam logic [WORD_W-1:0] ROW_STEP = MIX_MUL + ROW_ADD;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration registers
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 6;
    localparam int ROWS_REG_W   = 3;
    localparam int WORDS_REG_W  = 6;
    localparam int HASHES_REG_W = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_ROWS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WORDS  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_HASHES = 2'd2;

    localparam logic [ROWS_REG_W-1:0]   ROWS_RESET   = 3'd4;
    localparam logic [WORDS_REG_W-1:0]  WORDS_RESET  = 6'd32;
    localparam logic [HASHES_REG_W-1:0] HASHES_RESET = 4'd3;

    // input codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_UPDATE = 1'b1;

    localparam logic [1:0] MODE_ANY      = 2'd0;
    localparam logic [1:0] MODE_NO_EXIST = 2'd1;
    localparam logic [1:0] MODE_EXIST    = 2'd2;
    localparam logic [1:0] MODE_CLEAR    = 2'd3;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_EXISTS = 1'b1;

    // job classes
    localparam logic [1:0] CLS_LOOKUP = 2'd0;
    localparam logic [1:0] CLS_INSERT = 2'd1;
    localparam logic [1:0] CLS_REJECT = 2'd2;
    localparam logic [1:0] CLS_CLEAR  = 2'd3;

    typedef struct packed {
        logic              operation;
        logic [1:0]        update_mode;
        logic [WORD_W-1:0] key;
    } in_word_t;

    typedef struct packed {
        logic found;
        logic status;
    } out_word_t;

    typedef struct packed {
        logic [1:0]        cls;
        logic [WORD_W-1:0] key;
    } job_t;

    typedef struct packed {
        logic [ROWS_CNT_W-1:0]   rows;
        logic [WORDS_W-1:0]      words;
        logic [HASHES_CNT_W-1:0] hashes;
    } cfg_t;

endpackage

>>> rtl/core/pbf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module pbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/pbf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbf_front: input classifier and job queue
// Sorts each input word into lookup, insert, reject or clear and holds the
// jobs in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
module pbf_front import pbf_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_word_t in_word,
    output logic     job_valid,
    input  logic     job_pop,
    output job_t     job
);

    job_t              q_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    job_t              new_job;

    always_comb
    begin
        new_job.key = in_word.key;
        if (in_word.operation == OP_LOOKUP)
        begin
            new_job.cls = CLS_LOOKUP;
        end
        else
        begin
            case (in_word.update_mode)
                MODE_NO_EXIST: new_job.cls = CLS_REJECT;
                MODE_CLEAR:    new_job.cls = CLS_CLEAR;
                default:       new_job.cls = CLS_INSERT;
            endcase
        end
    end

    assign in_stall  = (int'(count_reg) == QUEUE_DEPTH);
    assign job_valid = (count_reg != '0);
    assign job       = q_reg[rd_ptr_reg];
    assign push      = in_valid && !in_stall;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (job_pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !job_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && job_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= new_job;
        end
    end

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> count_reg != '0)
        else $error("job popped from empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !job_pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost a push");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= QUEUE_DEPTH)
        else $error("queue count above depth");

endmodule

>>> rtl/core/pbf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbf_back: hash engine and bit store
// Walks every row and hash of a lookup or insert: byte-serial one-at-a-time
// hash, modulo by the row size, then a read-modify-write or test of one store bit.
// ----------------------------------------------------------------------------
module pbf_back import pbf_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      job_valid,
    output logic      job_pop,
    input  job_t      job,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_HASH = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_MOD  = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_UPD  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    function automatic logic [WORD_W-1:0] oaat_byte(input logic [WORD_W-1:0] h_in,
                                                    input logic [7:0] b);
        logic [WORD_W-1:0] h;
        h = h_in + WORD_W'(b);
        h = h + (h << 10);
        h = h ^ (h >> 6);
        return h;
    endfunction

    function automatic logic [WORD_W-1:0] oaat_fin(input logic [WORD_W-1:0] h_in);
        logic [WORD_W-1:0] h;
        h = h_in + (h_in << 3);
        h = h ^ (h >> 11);
        h = h + (h << 15);
        return h;
    endfunction

    function automatic logic [REM_W-1:0] mod_step(input logic [REM_W-1:0] rem_in,
                                                  input logic [MOD_STEP-1:0] bits,
                                                  input logic [WORDS_W-1:0] words);
        logic [REM_W:0]   t;
        logic [REM_W-1:0] rem;
        rem = rem_in;
        for (int k = MOD_STEP - 1; k >= 0; k--)
        begin
            t = {rem, bits[k]};
            if (t >= (REM_W + 1)'(words))
            begin
                t = t - (REM_W + 1)'(words);
            end
            rem = t[REM_W-1:0];
        end
        return rem;
    endfunction

    logic [2:0]             state_reg, state_next;
    logic [1:0]             cls_reg, cls_next;
    logic [WORD_W-1:0]      mix_reg, mix_next;
    logic [WORD_W-1:0]      row_mix_reg, row_mix_next;
    logic [WORD_W-1:0]      h_reg, h_next;
    logic [DIV_PAD-1:0]     div_reg, div_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [BIT_IDX_W-1:0]   bit_reg, bit_next;
    logic [ADDR_W-1:0]      addr_reg, addr_next;
    logic [ADDR_W-1:0]      row_base_reg, row_base_next;
    logic [ROW_W-1:0]       r_reg, r_next;
    logic [HASH_W-1:0]      i_reg, i_next;
    logic [BYTE_W-1:0]      byte_reg, byte_next;
    logic [MOD_CNT_W-1:0]   mod_cnt_reg, mod_cnt_next;
    logic                   all_reg, all_next;
    logic                   vbit_reg, vbit_next;
    logic [STORE_WORDS-1:0] valid_reg, valid_next;
    logic                   out_valid_reg, out_valid_next;
    out_word_t              out_word_reg, out_word_next;
    out_word_t              res_reg, res_next;

    logic [WORD_W-1:0] fin_hash;
    logic [WORD_W-1:0] cur_word;
    logic [WORD_W-1:0] ram_rdata;
    logic              ram_we;
    logic              ram_re;
    logic              out_free;
    logic              last_hash;
    logic              last_row;

    assign fin_hash  = oaat_fin(h_reg);
    assign cur_word  = vbit_reg ? ram_rdata : '0;
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_hash = (int'(i_reg) == int'(cfg.hashes) - 1);
    assign last_row  = (int'(r_reg) == int'(cfg.rows) - 1);
    assign ram_re    = (state_reg == S_READ);
    assign ram_we    = (state_reg == S_UPD) && (cls_reg == CLS_INSERT);
    assign job_pop   = (state_reg == S_IDLE) && job_valid;

    always_comb
    begin
        state_next    = state_reg;
        cls_next      = cls_reg;
        mix_next      = mix_reg;
        row_mix_next  = row_mix_reg;
        h_next        = h_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        bit_next      = bit_reg;
        addr_next     = addr_reg;
        row_base_next = row_base_reg;
        r_next        = r_reg;
        i_next        = i_reg;
        byte_next     = byte_reg;
        mod_cnt_next  = mod_cnt_reg;
        all_next      = all_reg;
        vbit_next     = vbit_reg;
        valid_next    = valid_reg;
        res_next      = res_reg;
        out_word_next = out_word_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    cls_next        = job.cls;
                    mix_next        = job.key * MIX_MUL;
                    row_mix_next    = job.key * MIX_MUL;
                    h_next          = '0;
                    byte_next       = '0;
                    r_next          = '0;
                    i_next          = '0;
                    row_base_next   = '0;
                    all_next        = 1'b1;
                    res_next.found  = 1'b0;
                    res_next.status = STATUS_OK;
                    case (job.cls)
                        CLS_REJECT:
                        begin
                            res_next.status = STATUS_EXISTS;
                            state_next      = S_DONE;
                        end
                        CLS_CLEAR:
                        begin
                            valid_next = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_HASH;
                        end
                    endcase
                end
            end
            S_HASH:
            begin
                h_next    = oaat_byte(h_reg, mix_reg[8*byte_reg +: 8]);
                byte_next = byte_reg + 1'b1;
                if (int'(byte_reg) == KEY_BYTES - 1)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                div_next     = DIV_PAD'(fin_hash >> BIT_IDX_W);
                bit_next     = fin_hash[BIT_IDX_W-1:0];
                rem_next     = '0;
                mod_cnt_next = '0;
                state_next   = S_MOD;
            end
            S_MOD:
            begin
                rem_next     = mod_step(rem_reg, div_reg[DIV_PAD-1 -: MOD_STEP], cfg.words);
                div_next     = div_reg << MOD_STEP;
                mod_cnt_next = mod_cnt_reg + 1'b1;
                if (int'(mod_cnt_reg) == MOD_CYCLES - 1)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                addr_next  = ADDR_W'(row_base_reg + ADDR_W'(rem_reg));
                vbit_next  = valid_reg[addr_next];
                state_next = S_UPD;
            end
            S_UPD:
            begin
                if (cls_reg == CLS_INSERT)
                begin
                    valid_next[addr_reg] = 1'b1;
                end
                else if (!cur_word[bit_reg])
                begin
                    all_next = 1'b0;
                end
                h_next    = '0;
                byte_next = '0;
                if (!last_hash)
                begin
                    i_next     = i_reg + 1'b1;
                    mix_next   = mix_reg + HASH_ADD;
                    state_next = S_HASH;
                end
                else if (!last_row)
                begin
                    i_next        = '0;
                    r_next        = r_reg + 1'b1;
                    row_mix_next  = row_mix_reg + ROW_STEP;
                    mix_next      = row_mix_reg + ROW_STEP;
                    row_base_next = ADDR_W'(row_base_reg + ADDR_W'(cfg.words));
                    state_next    = S_HASH;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_word_next.found  = (cls_reg == CLS_LOOKUP) ? all_reg : res_reg.found;
                    out_word_next.status = res_reg.status;
                    out_valid_next       = 1'b1;
                    state_next           = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cls_reg      <= cls_next;
        mix_reg      <= mix_next;
        row_mix_reg  <= row_mix_next;
        h_reg        <= h_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        bit_reg      <= bit_next;
        addr_reg     <= addr_next;
        row_base_reg <= row_base_next;
        r_reg        <= r_next;
        i_reg        <= i_next;
        byte_reg     <= byte_next;
        mod_cnt_reg  <= mod_cnt_next;
        all_reg      <= all_next;
        vbit_reg     <= vbit_next;
        res_reg      <= res_next;
        out_word_reg <= out_word_next;
    end

    pbf_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STORE_WORDS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr_reg),
        .wdata (cur_word | (BIT_ONE << bit_reg)),
        .re    (ram_re),
        .raddr (addr_next),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_upd_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD |-> $past(state_reg) == S_READ)
        else $error("store update without a read");

    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> int'(addr_next) < STORE_WORDS)
        else $error("store address out of range");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside completion");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_READ |-> rem_reg < REM_W'(cfg.words))
        else $error("row word index not below row size");

endmodule

>>> rtl/core/partitioned_bloom_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partitioned_bloom_filter: Bloom filter over a row-partitioned bit store
// Input words carry an operation, an update mode and a 32-bit key; each
// gives exactly one output word with found and status.
// Input channel: a word is taken when in_valid is high and in_stall low.
// A two-entry job queue sits behind the input, so up to two words are
// taken while the engine is busy; in_stall rises when the queue is full.
// Output channel: held in a result register until out_valid && !out_stall.
// While the receiver stalls, the engine parks the finished word and the
// queue keeps filling.
// Lookup and insert walk every row and hash in turn: 4 hash bytes, final
// mix, modulo steps of 7 quotient bits each, store read, store update.
// Reject and clear skip that walk. The hash/modulo/read-modify-write
// loop sets how long a lookup or insert takes.
// Configuration: cfg_valid/cfg_ready write channel, always ready; write
// only while no word is in flight. Unused indexes are ignored.
// Reset clears all store valid flags at once: no clearing pass, and the
// block accepts words in the first cycle after reset.
// ----------------------------------------------------------------------------
module partitioned_bloom_filter import pbf_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_word_t               in_word,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_word_t              out_word,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    function automatic int clamp_reg(input int v, input int hi);
        if (v == 0)
        begin
            return 1;
        end
        return (v > hi) ? hi : v;
    endfunction

    logic [ROWS_REG_W-1:0]   rows_reg, rows_next;
    logic [WORDS_REG_W-1:0]  words_reg, words_next;
    logic [HASHES_REG_W-1:0] hashes_reg, hashes_next;
    cfg_t                    cfg;
    logic                    job_valid;
    logic                    job_pop;
    job_t                    job;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        rows_next   = rows_reg;
        words_next  = words_reg;
        hashes_next = hashes_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ROWS:   rows_next   = cfg_data[ROWS_REG_W-1:0];
                REG_WORDS:  words_next  = cfg_data[WORDS_REG_W-1:0];
                REG_HASHES: hashes_next = cfg_data[HASHES_REG_W-1:0];
                default:    rows_next   = rows_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= ROWS_RESET;
            words_reg  <= WORDS_RESET;
            hashes_reg <= HASHES_RESET;
        end
        else
        begin
            rows_reg   <= rows_next;
            words_reg  <= words_next;
            hashes_reg <= hashes_next;
        end
    end

    assign cfg.rows   = ROWS_CNT_W'(clamp_reg(int'(rows_reg), MAX_ROWS));
    assign cfg.words  = WORDS_W'(clamp_reg(int'(words_reg), MAX_ROW_WORDS));
    assign cfg.hashes = HASHES_CNT_W'(clamp_reg(int'(hashes_reg), MAX_HASHES));

    pbf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job)
    );

    pbf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_valid (job_valid),
        .job_pop   (job_pop),
        .job       (job),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule
